// ----- hw/rtl/spime_pkg.sv -----
package spime_pkg;

    // frame length and counter widths
    localparam int FRAME_BITS = 8;
    localparam int BIT_CNT_W  = $clog2(FRAME_BITS + 1);
    localparam int PRESCALE_W = 7;
    localparam int BAUD_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 3;

    // request opcodes
    localparam logic [1:0] OP_WRITE_DATA  = 2'd0;
    localparam logic [1:0] OP_READ_DATA   = 2'd1;
    localparam logic [1:0] OP_READ_STATUS = 2'd2;
    localparam logic [1:0] OP_TICK        = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BAUD_EXPONENT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_POLARITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_PHASE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE         = 3'd4;

    // status byte layout
    localparam int STATUS_RX_FULL_BIT  = 0;
    localparam int STATUS_TX_EMPTY_BIT = 1;
    localparam int STATUS_BUSY_BIT     = 7;

    // classified request, as held in the queue
    typedef struct packed {
        logic                  is_write;
        logic                  is_read;
        logic                  is_status;
        logic                  is_tick;
        logic [FRAME_BITS-1:0] write_byte;
        logic                  miso_level;
    } t_req;

endpackage

// ----- hw/rtl/spime_front.sv -----
module spime_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_op,
    input  logic [spime_pkg::FRAME_BITS-1:0] i_write_byte,
    input  logic                          i_miso_level,
    output logic                          o_q_valid,
    output spime_pkg::t_req               o_q_req,
    input  logic                          i_q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    spime_pkg::t_req r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;

    spime_pkg::t_req w_req;
    logic            w_push;
    logic            w_pop;

    // decode the opcode into one flag per request kind
    always_comb begin
        w_req            = '0;
        w_req.write_byte = i_write_byte;
        w_req.miso_level = i_miso_level;
        unique case (i_op)
            spime_pkg::OP_WRITE_DATA:  w_req.is_write  = 1'b1;
            spime_pkg::OP_READ_DATA:   w_req.is_read   = 1'b1;
            spime_pkg::OP_READ_STATUS: w_req.is_status = 1'b1;
            spime_pkg::OP_TICK:        w_req.is_tick   = 1'b1;
            default:                   w_req.is_tick   = 1'b1;
        endcase
    end

    assign o_in_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push     = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_count != '0);
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_req    = r_mem[r_head];

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (w_push) begin
            n_tail = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (w_pop) begin
            n_head = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_tail] <= w_req;
        end
    end

endmodule

// ----- hw/rtl/spime_back.sv -----
module spime_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [spime_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [spime_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_q_valid,
    input  spime_pkg::t_req                   i_q_req,
    output logic                              o_q_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [spime_pkg::FRAME_BITS-1:0]  o_read_value,
    output logic                              o_sck_level,
    output logic                              o_mosi_level
);

    localparam int FB = spime_pkg::FRAME_BITS;
    localparam int PW = spime_pkg::PRESCALE_W;
    localparam int BW = spime_pkg::BIT_CNT_W;

    // configuration
    logic [spime_pkg::BAUD_W-1:0] r_baud;
    logic r_cpol, r_cpha, r_lsb_first, r_enable;

    // shifter state
    logic [FB-1:0] r_tx_buffer, n_tx_buffer;
    logic          r_tx_empty, n_tx_empty;
    logic [FB-1:0] r_shift, n_shift;
    logic [FB-1:0] r_rx_buffer, n_rx_buffer;
    logic          r_rx_full, n_rx_full;
    logic [BW-1:0] r_bit_count, n_bit_count;
    logic [PW-1:0] r_prescale, n_prescale;
    logic          r_sck, n_sck;
    logic          r_shifting, n_shifting;
    logic          r_mosi, n_mosi;

    // result register
    logic          r_out_valid;
    logic [FB-1:0] r_read_value, n_read_value;
    logic          r_out_sck;
    logic          r_out_mosi;

    logic w_take;
    logic w_leading;
    logic w_half_done;

    assign o_q_pop = i_q_valid && (!r_out_valid || i_out_ready);
    assign w_take  = o_q_pop;

    assign w_half_done = ((PW + 1)'(r_prescale) + 1'b1) >= ((PW + 1)'(1) << r_baud);
    assign w_leading   = (r_sck == r_cpol);

    always_comb begin
        n_tx_buffer  = r_tx_buffer;
        n_tx_empty   = r_tx_empty;
        n_shift      = r_shift;
        n_rx_buffer  = r_rx_buffer;
        n_rx_full    = r_rx_full;
        n_bit_count  = r_bit_count;
        n_prescale   = r_prescale;
        n_sck        = r_sck;
        n_shifting   = r_shifting;
        n_mosi       = r_mosi;
        n_read_value = '0;

        priority if (i_q_req.is_write) begin
            n_tx_buffer = i_q_req.write_byte;
            n_tx_empty  = 1'b0;
        end else if (i_q_req.is_read) begin
            n_read_value = r_rx_buffer;
            n_rx_full    = 1'b0;
        end else if (i_q_req.is_status) begin
            n_read_value[spime_pkg::STATUS_RX_FULL_BIT]  = r_rx_full;
            n_read_value[spime_pkg::STATUS_TX_EMPTY_BIT] = r_tx_empty;
            n_read_value[spime_pkg::STATUS_BUSY_BIT]     = r_shifting;
        end else if (!r_enable) begin
            // disabled tick aborts any running frame
            n_shifting  = 1'b0;
            n_bit_count = '0;
            n_prescale  = '0;
        end else if (!r_shifting) begin
            n_sck = r_cpol;
            if (!r_tx_empty) begin
                n_shift     = r_tx_buffer;
                n_tx_empty  = 1'b1;
                n_shifting  = 1'b1;
                n_bit_count = '0;
                n_prescale  = '0;
                if (!r_cpha) begin
                    // phase 0 puts the first bit out before the first edge
                    n_mosi  = r_lsb_first ? r_tx_buffer[0] : r_tx_buffer[FB-1];
                    n_shift = r_lsb_first ? (r_tx_buffer >> 1) : (r_tx_buffer << 1);
                end
            end
        end else if (!w_half_done) begin
            n_prescale = r_prescale + 1'b1;
        end else begin
            n_prescale = '0;
            n_sck      = ~r_sck;
            if (w_leading == r_cpha) begin
                // launch edge: leading with phase 1, trailing with phase 0
                if (!r_cpha && (r_bit_count >= BW'(FB))) begin
                    n_rx_buffer = r_shift;
                    n_rx_full   = 1'b1;
                    n_shifting  = 1'b0;
                    n_bit_count = '0;
                end else begin
                    n_mosi  = r_lsb_first ? r_shift[0] : r_shift[FB-1];
                    n_shift = r_lsb_first ? (r_shift >> 1) : (r_shift << 1);
                end
            end else begin
                // capture edge
                if (r_bit_count < BW'(FB)) begin
                    if (r_lsb_first) begin
                        n_shift[FB-1] = r_shift[FB-1] | i_q_req.miso_level;
                    end else begin
                        n_shift[0] = r_shift[0] | i_q_req.miso_level;
                    end
                    n_bit_count = r_bit_count + 1'b1;
                end
                if (r_cpha && (n_bit_count >= BW'(FB))) begin
                    n_rx_buffer = n_shift;
                    n_rx_full   = 1'b1;
                    n_shifting  = 1'b0;
                    n_bit_count = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baud      <= 3'd7;
            r_cpol      <= 1'b1;
            r_cpha      <= 1'b1;
            r_lsb_first <= 1'b0;
            r_enable    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                spime_pkg::CFG_BAUD_EXPONENT:  r_baud      <= i_cfg_data;
                spime_pkg::CFG_CLOCK_POLARITY: r_cpol      <= i_cfg_data[0];
                spime_pkg::CFG_CLOCK_PHASE:    r_cpha      <= i_cfg_data[0];
                spime_pkg::CFG_LSB_FIRST:      r_lsb_first <= i_cfg_data[0];
                spime_pkg::CFG_ENABLE:         r_enable    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_buffer <= '0;
            r_tx_empty  <= 1'b1;
            r_shift     <= '0;
            r_rx_buffer <= '0;
            r_rx_full   <= 1'b0;
            r_bit_count <= '0;
            r_prescale  <= '0;
            r_sck       <= 1'b1;
            r_shifting  <= 1'b0;
            r_mosi      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_tx_buffer <= n_tx_buffer;
                r_tx_empty  <= n_tx_empty;
                r_shift     <= n_shift;
                r_rx_buffer <= n_rx_buffer;
                r_rx_full   <= n_rx_full;
                r_bit_count <= n_bit_count;
                r_prescale  <= n_prescale;
                r_sck       <= n_sck;
                r_shifting  <= n_shifting;
                r_mosi      <= n_mosi;
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_read_value <= n_read_value;
            r_out_sck    <= n_shifting ? n_sck : r_cpol;
            r_out_mosi   <= n_mosi;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_sck_level  = r_out_sck;
    assign o_mosi_level = r_out_mosi;

endmodule

// ----- hw/rtl/spi_master_byte_exchange.sv -----
// full-duplex 8-bit spi master driven by a stream of bus requests (write data, read data,
// read status, clock tick); every request gives exactly one result carrying the read value
// and the sck and mosi levels after it. one request is taken per clock cycle when the result
// side keeps up: the classifying front end pushes into a short queue and the back end retires
// one request a cycle, the whole shifter update for one request being combinational logic,
// with a registered result stage in front of the output. an accepted request passes a queue
// entry, then the result register. sck toggles every 2^baud_exponent tick requests while a
// frame runs. configuration is written through a plain write port, indexes 0 baud exponent,
// 1 cpol (clock polarity), 2 cpha (clock phase), 3 lsb first, 4 enable; other indexes are ignored
module spi_master_byte_exchange #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_wr_en,
    input  logic [spime_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spime_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [1:0]                       i_op,
    input  logic [spime_pkg::FRAME_BITS-1:0] i_write_byte,
    input  logic                             i_miso_level,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [spime_pkg::FRAME_BITS-1:0] o_read_value,
    output logic                             o_sck_level,
    output logic                             o_mosi_level
);

    logic            w_q_valid;
    spime_pkg::t_req w_q_req;
    logic            w_q_pop;

    // front end: opcode decode and request queue
    spime_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_write_byte (i_write_byte),
        .i_miso_level (i_miso_level),
        .o_q_valid    (w_q_valid),
        .o_q_req      (w_q_req),
        .i_q_pop      (w_q_pop)
    );

    // back end: buffers, flags, prescaler, shifter and result register
    spime_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_q_valid    (w_q_valid),
        .i_q_req      (w_q_req),
        .o_q_pop      (w_q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_value (o_read_value),
        .o_sck_level  (o_sck_level),
        .o_mosi_level (o_mosi_level)
    );

endmodule

// ----- tb/sv/spi_master_byte_exchange_test.sv -----
`timescale 1ns / 1ps

module spi_master_byte_exchange_test;

    // generous ceiling on run length, in clock cycles
    localparam int CYCLE_LIMIT = 2_000_000;

    // levels expected on the result channel for one request
    typedef struct {
        logic [spime_pkg::FRAME_BITS-1:0] read_value;
        logic                             sck;
        logic                             mosi;
    } t_levels;

    // tracks the shifter, buffers and flags, and holds the levels still owed by the block
    class spi_exchange_board;
        // configuration copy
        logic [spime_pkg::BAUD_W-1:0]     baud_exp;
        logic                             cpol;
        logic                             cpha;
        logic                             lsb_first;
        logic                             enabled;
        // shifter and buffer copy
        logic [spime_pkg::FRAME_BITS-1:0] tx_hold;
        logic [spime_pkg::FRAME_BITS-1:0] shifter;
        logic [spime_pkg::FRAME_BITS-1:0] rx_hold;
        logic                             tx_empty;
        logic                             rx_full;
        logic                             running;
        logic                             sck;
        logic                             mosi;
        logic [spime_pkg::BIT_CNT_W-1:0]  bits_taken;
        logic [spime_pkg::PRESCALE_W-1:0] prescale;
        t_levels                          awaited[$];
        int                               errors;

        function new();
            baud_exp  = 3'd7;
            cpol      = 1'b1;
            cpha      = 1'b1;
            lsb_first = 1'b0;
            enabled   = 1'b0;
            tx_hold   = '0;
            shifter   = '0;
            rx_hold   = '0;
            tx_empty  = 1'b1;
            rx_full   = 1'b0;
            mosi      = 1'b0;
            errors    = 0;
            stop_frame();
        endfunction

        function void stop_frame();
            running    = 1'b0;
            bits_taken = '0;
            prescale   = '0;
            sck        = cpol;
        endfunction

        function void shift_out();
            if (lsb_first) begin
                mosi    = shifter[0];
                shifter = shifter >> 1;
            end else begin
                mosi    = shifter[spime_pkg::FRAME_BITS-1];
                shifter = shifter << 1;
            end
        endfunction

        function void shift_in(logic m);
            if (bits_taken >= spime_pkg::FRAME_BITS)
                return;
            if (lsb_first)
                shifter[spime_pkg::FRAME_BITS-1] = shifter[spime_pkg::FRAME_BITS-1] | m;
            else
                shifter[0] = shifter[0] | m;
            bits_taken = bits_taken + 1'b1;
        endfunction

        function void end_frame();
            rx_hold = shifter;
            rx_full = 1'b1;
            stop_frame();
        endfunction

        function void toggle_sck(logic m);
            logic leading;
            leading = (sck == cpol);
            sck = ~sck;
            if (leading) begin
                if (cpha)
                    shift_out();
                else
                    shift_in(m);
            end else if (cpha) begin
                shift_in(m);
                if (bits_taken >= spime_pkg::FRAME_BITS)
                    end_frame();
            end else if (bits_taken >= spime_pkg::FRAME_BITS) begin
                end_frame();
            end else begin
                shift_out();
            end
        endfunction

        function void clock_tick(logic m);
            if (!enabled) begin
                stop_frame();
                return;
            end
            if (!running) begin
                sck = cpol;
                if (!tx_empty) begin
                    shifter    = tx_hold;
                    tx_empty   = 1'b1;
                    running    = 1'b1;
                    bits_taken = '0;
                    prescale   = '0;
                    if (!cpha)
                        shift_out();
                end
                return;
            end
            if (32'(prescale) + 32'd1 >= (32'd1 << baud_exp)) begin
                prescale = '0;
                toggle_sck(m);
            end else begin
                prescale = prescale + 1'b1;
            end
        endfunction

        function void set_register(logic [spime_pkg::CFG_IDX_W-1:0] idx,
                                   logic [spime_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                spime_pkg::CFG_BAUD_EXPONENT:  baud_exp  = data[spime_pkg::BAUD_W-1:0];
                spime_pkg::CFG_CLOCK_POLARITY: cpol      = data[0];
                spime_pkg::CFG_CLOCK_PHASE:    cpha      = data[0];
                spime_pkg::CFG_LSB_FIRST:      lsb_first = data[0];
                spime_pkg::CFG_ENABLE:         enabled   = data[0];
                default: ;
            endcase
            if (!running)
                sck = cpol;
        endfunction

        function void note_request(logic [1:0] op, logic [spime_pkg::FRAME_BITS-1:0] wb,
                                   logic m);
            t_levels lv;
            lv.read_value = '0;
            case (op)
                spime_pkg::OP_WRITE_DATA: begin
                    tx_hold  = wb;
                    tx_empty = 1'b0;
                end
                spime_pkg::OP_READ_DATA: begin
                    lv.read_value = rx_hold;
                    rx_full       = 1'b0;
                end
                spime_pkg::OP_READ_STATUS: begin
                    lv.read_value[spime_pkg::STATUS_RX_FULL_BIT]  = rx_full;
                    lv.read_value[spime_pkg::STATUS_TX_EMPTY_BIT] = tx_empty;
                    lv.read_value[spime_pkg::STATUS_BUSY_BIT]     = running;
                end
                default: clock_tick(m);
            endcase
            if (!running)
                sck = cpol;
            lv.sck  = sck;
            lv.mosi = mosi;
            awaited.push_back(lv);
        endfunction

        function void check_result(logic [spime_pkg::FRAME_BITS-1:0] rv, logic s, logic m);
            t_levels lv;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual read_value %h sck %b mosi %b",
                         $time, rv, s, m);
                errors++;
                return;
            end
            lv = awaited.pop_front();
            if (rv !== lv.read_value) begin
                $display("%0t: read_value expected %h actual %h", $time, lv.read_value, rv);
                errors++;
            end
            if (s !== lv.sck) begin
                $display("%0t: sck_level expected %b actual %b", $time, lv.sck, s);
                errors++;
            end
            if (m !== lv.mosi) begin
                $display("%0t: mosi_level expected %b actual %b", $time, lv.mosi, m);
                errors++;
            end
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_wr_en;
    logic [spime_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [spime_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic [1:0]                       i_op;
    logic [spime_pkg::FRAME_BITS-1:0] i_write_byte;
    logic                             i_miso_level;
    logic                             o_out_valid;
    logic                             i_out_ready;
    logic [spime_pkg::FRAME_BITS-1:0] o_read_value;
    logic                             o_sck_level;
    logic                             o_mosi_level;

    spi_exchange_board board = new();

    int sent_count;
    int burst_left;
    int cycles = 0;

    spi_master_byte_exchange u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_write_byte (i_write_byte),
        .i_miso_level (i_miso_level),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_value (o_read_value),
        .o_sck_level  (o_sck_level),
        .o_mosi_level (o_mosi_level)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog, a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("spi_master_byte_exchange_test NOT OK");
            $finish;
        end
    end

    // both handshakes sampled at the rising edge; the result is checked before the
    // request of the same edge is noted, so a fresh request can never cover a stray result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                board.check_result(o_read_value, o_sck_level, o_mosi_level);
            if (i_in_valid && o_in_ready)
                board.note_request(i_op, i_write_byte, i_miso_level);
        end
    end

    // result side back-pressure: each randomly chosen mode holds for a random stretch,
    // steady ready being one of the modes
    initial begin
        int mode;
        int mode_left;
        int phase_cnt;
        mode      = 0;
        mode_left = 0;
        phase_cnt = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            phase_cnt++;
            case (mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                2:       i_out_ready <= ((phase_cnt % 7) >= 3);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // one request on the input channel; bursts of random length with random gaps between
    task automatic send_request(input logic [1:0] op,
                                input logic [spime_pkg::FRAME_BITS-1:0] wb,
                                input logic m);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_write_byte <= wb;
        i_miso_level <= m;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        sent_count++;
    endtask

    // drop valid and wait for every owed result
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // write enable is left high; the caller lowers it after the last write
    task automatic write_register(input logic [spime_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [spime_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        board.set_register(idx, data);
    endtask

    // new settings for a phase; upper data bits of the one-bit registers are junk on purpose
    task automatic apply_random_settings(input bit force_slow);
        logic [spime_pkg::CFG_DATA_W-1:0] exp_val;
        logic [1:0]                       junk;
        logic                             en_bit;
        int                               r;
        r = $urandom_range(0, 19);
        if (force_slow)
            exp_val = 3'd7;
        else if (r < 14)
            exp_val = 3'($urandom_range(0, 1));
        else if (r < 18)
            exp_val = 3'($urandom_range(2, 4));
        else
            exp_val = 3'($urandom_range(5, 7));
        if (force_slow || $urandom_range(0, 3) != 0)
            write_register(spime_pkg::CFG_BAUD_EXPONENT, exp_val);
        if ($urandom_range(0, 2) != 0)
            write_register(spime_pkg::CFG_CLOCK_POLARITY, 3'($urandom_range(0, 7)));
        if ($urandom_range(0, 2) != 0)
            write_register(spime_pkg::CFG_CLOCK_PHASE, 3'($urandom_range(0, 7)));
        if ($urandom_range(0, 2) != 0)
            write_register(spime_pkg::CFG_LSB_FIRST, 3'($urandom_range(0, 7)));
        junk   = 2'($urandom_range(0, 3));
        en_bit = force_slow || ($urandom_range(0, 6) != 0);
        if (force_slow || $urandom_range(0, 2) != 0)
            write_register(spime_pkg::CFG_ENABLE, {junk, en_bit});
        // unused indexes must be ignored
        if ($urandom_range(0, 4) == 0)
            write_register(3'($urandom_range(5, 7)), 3'($urandom_range(0, 7)));
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // mostly well-formed exchanges: load a byte, tick through the frame, collect the
    // reply, with stray requests, early cut-offs and mid-frame loads mixed in
    task automatic run_exchange();
        int half;
        int budget;
        int k;
        int r;
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 8))
                send_request(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        end
        send_request(spime_pkg::OP_WRITE_DATA, 8'($urandom), 1'($urandom));
        // write while the buffer is still full
        if ($urandom_range(0, 4) == 0)
            send_request(spime_pkg::OP_WRITE_DATA, 8'($urandom), 1'($urandom));
        half   = 1 << board.baud_exp;
        budget = 1 + 2 * spime_pkg::FRAME_BITS * half + $urandom_range(0, 3);
        // slow rates are cut short so the frame runs on into the next settings
        if (budget > 300)
            budget = $urandom_range(150, 300);
        if ($urandom_range(0, 7) == 0)
            budget = $urandom_range(1, budget);
        for (k = 0; k < budget; k++) begin
            r = $urandom_range(0, 19);
            if (r == 0)
                send_request(spime_pkg::OP_READ_STATUS, 8'($urandom), 1'($urandom));
            else if (r == 1)
                send_request(spime_pkg::OP_WRITE_DATA, 8'($urandom), 1'($urandom));
            else if (r == 2)
                send_request(spime_pkg::OP_READ_DATA, 8'($urandom), 1'($urandom));
            send_request(spime_pkg::OP_TICK, 8'($urandom), 1'($urandom));
        end
        send_request(spime_pkg::OP_READ_STATUS, 8'($urandom), 1'($urandom));
        // skipping the read now and then lets the receive buffer be overwritten
        if ($urandom_range(0, 5) != 0)
            send_request(spime_pkg::OP_READ_DATA, 8'($urandom), 1'($urandom));
    endtask

    initial begin
        int k;
        int phase;
        sent_count   = 0;
        burst_left   = 0;
        i_rst_n      = 1'b0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_op         = spime_pkg::OP_READ_STATUS;
        i_write_byte = '0;
        i_miso_level = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, shifter disabled
        send_request(spime_pkg::OP_READ_STATUS, 8'h00, 1'b0);
        send_request(spime_pkg::OP_READ_DATA, 8'hFF, 1'b1);
        // tick while disabled does nothing
        send_request(spime_pkg::OP_TICK, 8'h00, 1'b1);
        send_request(spime_pkg::OP_WRITE_DATA, 8'h00, 1'b0);
        // write while full overwrites the buffer
        send_request(spime_pkg::OP_WRITE_DATA, 8'hFF, 1'b1);
        send_request(spime_pkg::OP_READ_STATUS, 8'h00, 1'b0);
        settle();

        // fastest rate, mode 0, msb first: one full frame then the reply
        write_register(spime_pkg::CFG_BAUD_EXPONENT, 3'd0);
        write_register(spime_pkg::CFG_CLOCK_POLARITY, 3'd0);
        write_register(spime_pkg::CFG_CLOCK_PHASE, 3'd0);
        write_register(spime_pkg::CFG_LSB_FIRST, 3'd0);
        write_register(spime_pkg::CFG_ENABLE, 3'd1);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        for (k = 0; k < 1 + 2 * spime_pkg::FRAME_BITS; k++)
            send_request(spime_pkg::OP_TICK, 8'($urandom), 1'(k >> 1));
        send_request(spime_pkg::OP_READ_STATUS, 8'h00, 1'b0);
        send_request(spime_pkg::OP_READ_DATA, 8'h00, 1'b0);
        send_request(spime_pkg::OP_READ_STATUS, 8'h00, 1'b0);

        // random phases; the second runs at the slowest rate
        phase = 0;
        while (sent_count < 1120) begin
            settle();
            apply_random_settings(phase == 1);
            run_exchange();
            phase++;
        end

        settle();
        repeat (8) @(negedge i_clk);
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("spi_master_byte_exchange_test OK");
        else
            $display("spi_master_byte_exchange_test NOT OK");
        $finish;
    end

endmodule
